@@ rtl/core/ltws_pkg.sv @@
// Shared types and constants for the LOESS tricube window sums block.
// No dependencies.
package ltws_pkg;
  localparam int unsigned DEF_MAX_WINDOW = 1024;
  localparam int unsigned QDEPTH = 2;
  localparam logic [24:0] ONE_Q24 = 25'h1000000;
  localparam logic [31:0] STEP_X = 32'd4096;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] xmag;
    logic        xneg;
    logic [31:0] ymag;
    logic        yneg;
    logic [24:0] inv;
    logic        wflag;
    logic [16:0] uw;
    logic        clear;
    logic        last;
  } item_t;

  function automatic logic [63:0] to_signed64(input logic [63:0] mag, input logic neg);
    if (neg) to_signed64 = mag[63] ? MIN64 : (~mag + 64'd1);
    else to_signed64 = mag[63] ? MAX64 : mag;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) sat_add64 = a[63] ? MIN64 : MAX64;
    else sat_add64 = s;
  endfunction
endpackage

@@ rtl/core/loess_tricube_window_sums.sv @@
// LOESS tricube window sums, top level.
// Depends on ltws_pkg, ltws_front and ltws_back.
//
// Samples of one window arrive on the in_ valid/ready channel; the sample
// marked first_sample latches base_x, inv_bandwidth and weights_present and
// clears the sums. Each sample sits one Q20.12 unit past the previous one.
// The sample marked last_sample yields one transfer on the out_ channel with
// the five saturating sums.
// A two-entry queue parts the front, which accepts and classifies samples,
// from the back, which runs a sequenced multiplier chain per sample and
// skips the tricube steps for a sample at or past the bandwidth. The back
// takes no new sample until it has accumulated the last one, so its
// multiply sequence sets the throughput; out_valid rises together with the
// sums that hold the window's last sample.
// A stalled result holds the sums; the back waits before the next
// accumulation while the queue keeps accepting until full.
// Reset clears position, latched values, sums and the queue.
module loess_tricube_window_sums import ltws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_y,
  input  logic [16:0] in_user_weight,
  input  logic        in_weights_present,
  input  logic [31:0] in_base_x,
  input  logic [24:0] in_inv_bandwidth,
  input  logic        in_first_sample,
  input  logic        in_last_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_sum_weight,
  output logic [63:0] out_sum_weight_x,
  output logic [63:0] out_sum_weight_y,
  output logic [63:0] out_sum_weight_xx,
  output logic [63:0] out_sum_weight_xy
);
  logic  q_valid, q_ready;
  item_t q_item;

  ltws_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample_y, .in_user_weight,
    .in_weights_present, .in_base_x, .in_inv_bandwidth, .in_first_sample,
    .in_last_sample, .q_valid, .q_ready, .q_item
  );

  ltws_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .out_sum_weight, .out_sum_weight_x, .out_sum_weight_y,
    .out_sum_weight_xx, .out_sum_weight_xy
  );
endmodule

@@ rtl/core/ltws_front.sv @@
// Front end: position tracking, latching of window values, item classification.
// Depends on ltws_pkg.
module ltws_front import ltws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_y,
  input  logic [16:0] in_user_weight,
  input  logic        in_weights_present,
  input  logic [31:0] in_base_x,
  input  logic [24:0] in_inv_bandwidth,
  input  logic        in_first_sample,
  input  logic        in_last_sample,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);
  localparam int unsigned PW = $clog2(QDEPTH);
  item_t       q_mem [QDEPTH];
  logic [PW:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wp_r, rp_r;
  logic [31:0] x_r, x_cur;
  logic [24:0] inv_r, inv_cur;
  logic        wf_r, wf_cur;
  item_t       it;
  logic        push, pop;

  assign in_ready = cnt_r != (PW+1)'(QDEPTH);
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != '0;
  assign pop = q_valid && q_ready;
  assign q_item = q_mem[rp_r];

  always_comb begin
    x_cur = in_first_sample ? in_base_x : x_r;
    inv_cur = in_first_sample ? in_inv_bandwidth : inv_r;
    wf_cur = in_first_sample ? in_weights_present : wf_r;
    it.xneg = x_cur[31];
    it.xmag = x_cur[31] ? (~x_cur + 32'd1) : x_cur;
    it.yneg = in_sample_y[31];
    it.ymag = in_sample_y[31] ? (~in_sample_y + 32'd1) : in_sample_y;
    it.inv = inv_cur;
    it.wflag = wf_cur;
    it.uw = in_user_weight;
    it.clear = in_first_sample;
    it.last = in_last_sample;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
      x_r <= '0; inv_r <= '0; wf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
        x_r <= x_cur + STEP_X;
        inv_r <= inv_cur;
        wf_r <= wf_cur;
      end
      if (pop) rp_r <= (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wp_r] <= it;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDEPTH)) else $error("queue overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PW+1)'(QDEPTH)) |-> !in_ready) else $error("ready while full");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !in_first_sample) |=> x_r == $past(x_r) + STEP_X) else $error("x step");
endmodule

@@ rtl/core/ltws_back.sv @@
// Back end: sequenced tricube weight, products and saturating accumulation.
// Depends on ltws_pkg.
module ltws_back import ltws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_sum_weight,
  output logic [63:0] out_sum_weight_x,
  output logic [63:0] out_sum_weight_y,
  output logic [63:0] out_sum_weight_xx,
  output logic [63:0] out_sum_weight_xy
);
  typedef enum logic [3:0] {
    S_IDLE, S_P, S_U2, S_U3, S_T2, S_T3, S_UW, S_WX, S_XXL, S_XXH, S_ACC, S_OUT
  } st_t;
  st_t st_r;
  item_t it_r;
  logic [56:0] p_r;
  logic [24:0] u_r, a_r;
  logic [24:0] t_r;
  logic [16:0] w_r;
  logic [48:0] wx_r;
  logic [63:0] wy_r, lo_r, hi_r, mlo_r, mhi_r;
  logic [63:0] acc_w_r, acc_wx_r, acc_wy_r, acc_wxx_r, acc_wxy_r;
  logic [63:0] base_w, base_wx, base_wy, base_wxx, base_wxy;
  logic [49:0] prod;
  logic [63:0] mxx, mxy;
  logic        acc_go, out_valid_nxt;

  assign q_ready = st_r == S_IDLE;
  assign acc_go = (st_r == S_ACC) && (!out_valid || out_ready);

  function automatic logic [63:0] cap(input logic [63:0] hi, input logic [63:0] lo);
    logic [64:0] r;
    r = {1'b0, hi[31:0], 32'd0} + {1'b0, lo};
    if (hi >= 64'h8000_0000 || r > {1'b0, MIN64}) cap = MIN64;
    else cap = r[63:0];
  endfunction

  always_comb begin
    prod = 50'(a_r) * 50'(u_r);
    mxx = cap(hi_r, lo_r);
    mxy = cap(mhi_r, mlo_r);
    base_w = it_r.clear ? '0 : acc_w_r;
    base_wx = it_r.clear ? '0 : acc_wx_r;
    base_wy = it_r.clear ? '0 : acc_wy_r;
    base_wxx = it_r.clear ? '0 : acc_wxx_r;
    base_wxy = it_r.clear ? '0 : acc_wxy_r;
    out_valid_nxt = out_valid && !out_ready;
    if (acc_go) out_valid_nxt = it_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0;
      acc_w_r <= '0; acc_wx_r <= '0; acc_wy_r <= '0; acc_wxx_r <= '0; acc_wxy_r <= '0;
    end else begin
      out_valid <= out_valid_nxt;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          st_r <= S_P;
        end
        S_P: begin
          p_r <= 57'(it_r.xmag) * 57'(it_r.inv);
          st_r <= S_U2;
        end
        S_U2: begin
          if (p_r[56:36] != '0) begin
            w_r <= '0; st_r <= S_UW;
          end else begin
            u_r <= {1'b0, p_r[35:12]}; a_r <= {1'b0, p_r[35:12]};
            st_r <= S_U3;
          end
        end
        S_U3: begin
          a_r <= 25'(prod >> 24);
          st_r <= S_T2;
        end
        S_T2: begin
          t_r <= ONE_Q24 - 25'(prod >> 24);
          a_r <= ONE_Q24 - 25'(prod >> 24);
          u_r <= ONE_Q24 - 25'(prod >> 24);
          st_r <= S_T3;
        end
        S_T3: begin
          a_r <= 25'(prod >> 24);
          u_r <= t_r;
          st_r <= S_OUT;
        end
        S_OUT: begin
          w_r <= 17'(prod >> 32);
          st_r <= S_UW;
        end
        S_UW: begin
          if (it_r.wflag) w_r <= 17'((34'(w_r) * 34'(it_r.uw)) >> 16);
          st_r <= S_WX;
        end
        S_WX: begin
          wx_r <= 49'(w_r) * 49'(it_r.xmag);
          wy_r <= 64'(w_r) * 64'(it_r.ymag);
          st_r <= S_XXL;
        end
        S_XXL: begin
          lo_r <= 64'(wx_r[31:0]) * 64'(it_r.xmag);
          mlo_r <= 64'(wx_r[31:0]) * 64'(it_r.ymag);
          st_r <= S_XXH;
        end
        S_XXH: begin
          hi_r <= 64'(wx_r[48:32]) * 64'(it_r.xmag);
          mhi_r <= 64'(wx_r[48:32]) * 64'(it_r.ymag);
          st_r <= S_ACC;
        end
        S_ACC: if (acc_go) begin
          acc_w_r <= sat_add64(base_w, 64'(w_r));
          acc_wx_r <= sat_add64(base_wx, to_signed64(64'(wx_r), it_r.xneg));
          acc_wy_r <= sat_add64(base_wy, to_signed64(wy_r, it_r.yneg));
          acc_wxx_r <= sat_add64(base_wxx, to_signed64(mxx, 1'b0));
          acc_wxy_r <= sat_add64(base_wxy, to_signed64(mxy, it_r.xneg != it_r.yneg));
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_sum_weight = acc_w_r;
  assign out_sum_weight_x = acc_wx_r;
  assign out_sum_weight_y = acc_wy_r;
  assign out_sum_weight_xx = acc_wxx_r;
  assign out_sum_weight_xy = acc_wxy_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(acc_w_r) && $stable(acc_wxy_r))
    else $error("result changed while stalled");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |=> st_r == S_P) else $error("take");
  a_wpos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ACC && out_valid && !out_ready) |=> st_r == S_ACC) else $error("acc ran");
endmodule
